FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent at one edge requires the consequent at the next edge.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rstn, prop, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: hdl/tcptg_pkg.sv
package tcptg_pkg;

    // Item kinds carried in the input beat's tuser.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Channel register selectors.
    localparam logic [1:0] SEL_CONTROL = 2'd0;
    localparam logic [1:0] SEL_FREQ    = 2'd1;
    localparam logic [1:0] SEL_VOLUME  = 2'd2;

    // Control values with a meaning of their own.
    localparam logic [3:0] CTL_SILENT = 4'd0;
    localparam logic [3:0] CTL_POLY9  = 4'd8;

    // Last positions of the 31-step and 15-step patterns.
    localparam logic [4:0] P5_LAST = 5'd30;
    localparam logic [3:0] P4_LAST = 4'd14;

    // Pattern tables, entry i in bit i.
    localparam logic [14:0] PAT4   = 15'b111000010100110;
    localparam logic [30:0] PAT5   = 31'b1100101101111010100010011100000;
    localparam logic [30:0] PATD31 = 31'h0008_0002;

    // Configuration register indexes (word address bit 2).
    localparam logic CFG_SAMPLE_DIVISOR = 1'b0;
    localparam logic CFG_SINGLE_CHANNEL = 1'b1;

    localparam logic [15:0] DIVISOR_RESET = 16'd256;
    localparam logic [23:0] SAMPLE_STEP   = 24'd256;

    // Per-channel command for one accepted beat.
    typedef struct packed {
        logic       wr_en;
        logic       tick_en;
        logic [1:0] sel;
        logic [7:0] wdata;
    } chan_cmd_t;

endpackage

FILE: hdl/tcptg_channel.sv
`include "assert_macros.svh"

module tcptg_channel
    import tcptg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  chan_cmd_t  cmd,
    output logic [6:0] level_next
);

    logic [3:0] ctl_reg, ctl_next;
    logic [4:0] freq_reg, freq_next;
    logic [3:0] vol_reg, vol_next;
    logic [6:0] level_reg;
    logic [5:0] count_reg, count_next;
    logic [5:0] reload_reg, reload_next;
    logic [4:0] p5_reg, p5_next;
    logic [3:0] p4_reg, p4_next;
    logic [8:0] poly9_reg, poly9_next;

    always_comb begin
        logic       wr_ok;
        logic [5:0] nv;
        logic [6:0] loud;
        logic       gate;
        logic       fb;

        ctl_next    = ctl_reg;
        freq_next   = freq_reg;
        vol_next    = vol_reg;
        level_next  = level_reg;
        count_next  = count_reg;
        reload_next = reload_reg;
        p5_next     = p5_reg;
        p4_next     = p4_reg;
        poly9_next  = poly9_reg;
        wr_ok       = 1'b0;
        nv          = '0;
        loud        = {vol_reg, 3'b000};
        gate        = 1'b0;
        fb          = 1'b0;

        if (cmd.wr_en) begin
            wr_ok = 1'b1;
            unique case (cmd.sel)
                SEL_CONTROL: ctl_next  = cmd.wdata[3:0];
                SEL_FREQ:    freq_next = cmd.wdata[4:0];
                SEL_VOLUME:  vol_next  = cmd.wdata[3:0];
                default:     wr_ok     = 1'b0;
            endcase
            if (wr_ok) begin
                // Each accepted write recomputes the reload; a change starts a stopped count, or stops it if zero.
                if (ctl_next == CTL_SILENT) begin
                    nv         = '0;
                    level_next = {vol_next, 3'b000};
                end else begin
                    nv = {1'b0, freq_next} + 6'd1;
                end
                if (nv != reload_reg) begin
                    reload_next = nv;
                    if (count_reg == '0 || nv == '0) begin
                        count_next = nv;
                    end
                end
            end
        end else if (cmd.tick_en && count_reg != '0) begin
            if (count_reg > 6'd1) begin
                count_next = count_reg - 6'd1;
            end else begin
                count_next = reload_reg;
                p5_next    = (p5_reg == P5_LAST) ? 5'd0 : p5_reg + 5'd1;
                gate = !ctl_reg[1] ||
                       (!ctl_reg[0] && PATD31[p5_next]) ||
                       (ctl_reg[0] && PAT5[p5_next]);
                if (gate) begin
                    if (ctl_reg[2]) begin
                        level_next = (level_reg != '0) ? 7'd0 : loud;
                    end else if (ctl_reg[3]) begin
                        if (ctl_reg == CTL_POLY9) begin
                            fb         = poly9_reg[4] ^ poly9_reg[0];
                            poly9_next = {fb, poly9_reg[8:1]};
                            level_next = poly9_reg[0] ? loud : 7'd0;
                        end else begin
                            level_next = PAT5[p5_next] ? loud : 7'd0;
                        end
                    end else begin
                        p4_next    = (p4_reg == P4_LAST) ? 4'd0 : p4_reg + 4'd1;
                        level_next = PAT4[p4_next] ? loud : 7'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg    <= '0;
            freq_reg   <= '0;
            vol_reg    <= '0;
            level_reg  <= '0;
            count_reg  <= '0;
            reload_reg <= '0;
            p5_reg     <= '0;
            p4_reg     <= '0;
            poly9_reg  <= 9'd1;
        end else begin
            ctl_reg    <= ctl_next;
            freq_reg   <= freq_next;
            vol_reg    <= vol_next;
            level_reg  <= level_next;
            count_reg  <= count_next;
            reload_reg <= reload_next;
            p5_reg     <= p5_next;
            p4_reg     <= p4_next;
            poly9_reg  <= poly9_next;
        end
    end

    `ASSERT_ALWAYS(a_level_step, aclk, aresetn, level_reg[2:0] == 3'd0, "level not a multiple of eight")
    `ASSERT_ALWAYS(a_stopped_divider, aclk, aresetn, reload_reg != '0 || count_reg == '0, "divider runs with zero reload")
    `ASSERT_ALWAYS(a_pattern_pos, aclk, aresetn, p5_reg <= P5_LAST && p4_reg <= P4_LAST, "pattern position out of range")
    `ASSERT_ALWAYS(a_poly9_live, aclk, aresetn, poly9_reg != '0, "shift register locked at zero")

endmodule

FILE: hdl/two_channel_poly_tone_generator_unit.sv
// Two-channel tone generator with pattern and shift-register noise sources.
//
// Input stream: each beat is either a register write (tuser mode 0) that sets one
// channel's control, frequency or volume, or one audio clock tick (mode 1). A tick
// advances the channel dividers (channel 0's only while the single-channel flag is
// clear) and the 16.8 sample counter; when the counter runs out, the tick produces
// one output beat with the sum of the two channel levels; write beats produce none.
//
// Throughput is one input beat per cycle. All per-beat work is a single pass of
// small counter and table logic, and the result is held in one output register, so
// an output beat appears on the cycle after the tick that caused it. While that
// register holds an untaken beat and the receiver stalls, s_tready drops; it stays
// high whenever the register is empty or is being emptied in the same cycle.
//
// The APB port holds the sample divisor (address 0) and the single-channel flag
// (address 4); write them only while the stream is idle. The synchronous, active-low
// reset clears both channels, sets the divisor to 256 and empties the output register.
`include "assert_macros.svh"

module two_channel_poly_tone_generator_unit
    import tcptg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] channel, [8:1] write_data, [15:9] zero
    input  logic [2:0]  s_tuser,   // [0] mode, [2:1] reg_select
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] sample
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] sample_divisor_reg;
    logic        single_channel_reg;
    logic [23:0] sample_count_reg, sample_count_next;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;

    logic        in_beat;
    logic        mode;
    logic        emit;
    logic [23:0] count_dec;
    chan_cmd_t   cmd0, cmd1;
    logic [6:0]  level0_next, level1_next;

    // ------------------------------------------------------------------
    // Configuration registers. pready is tied high, so every access is a
    // plain setup/access pair with no wait states.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_divisor_reg <= DIVISOR_RESET;
            single_channel_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                CFG_SAMPLE_DIVISOR: sample_divisor_reg <= pwdata[15:0];
                CFG_SINGLE_CHANNEL: single_channel_reg <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_SAMPLE_DIVISOR: prdata = {16'd0, sample_divisor_reg};
            CFG_SINGLE_CHANNEL: prdata = {31'd0, single_channel_reg};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input beat decode. The output register frees up in the same cycle
    // that its beat is taken, so the input need not wait for a bubble.
    // ------------------------------------------------------------------
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;
    assign mode     = s_tuser[0];

    always_comb begin
        cmd0.wr_en   = in_beat && (mode == MODE_WRITE) && !s_tdata[0];
        cmd0.tick_en = in_beat && (mode == MODE_TICK) && !single_channel_reg;
        cmd0.sel     = s_tuser[2:1];
        cmd0.wdata   = s_tdata[8:1];
        cmd1.wr_en   = in_beat && (mode == MODE_WRITE) && s_tdata[0];
        cmd1.tick_en = in_beat && (mode == MODE_TICK);
        cmd1.sel     = s_tuser[2:1];
        cmd1.wdata   = s_tdata[8:1];
    end

    tcptg_channel u_chan0 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd0),
        .level_next (level0_next)
    );

    tcptg_channel u_chan1 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd1),
        .level_next (level1_next)
    );

    // ------------------------------------------------------------------
    // Sample counter: every tick takes one whole unit (256 in 8.8) off the
    // signed count; once it falls below one unit a sample is due and the
    // divisor is added back.
    // ------------------------------------------------------------------
    assign count_dec = sample_count_reg - SAMPLE_STEP;
    assign emit      = in_beat && (mode == MODE_TICK) &&
                       ($signed(count_dec) < $signed(SAMPLE_STEP));

    always_comb begin
        sample_count_next = sample_count_reg;
        if (in_beat && mode == MODE_TICK) begin
            sample_count_next = emit ? count_dec + {8'd0, sample_divisor_reg} : count_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            sample_count_reg <= sample_count_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // The beat carries the levels as they stand after this tick.
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= {1'b0, level0_next} + {1'b0, level1_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_NEXT(a_write_no_result, aclk, aresetn, in_beat && mode == MODE_WRITE && s_tready && !(m_tvalid_reg && !m_tready), !m_tvalid_reg, "write beat produced a result")
    `ASSERT_NEXT(a_write_keeps_count, aclk, aresetn, !(in_beat && mode == MODE_TICK), $stable(sample_count_reg), "sample counter moved without a tick")
    `ASSERT_ALWAYS(a_sample_step, aclk, aresetn, !m_tvalid_reg || m_tdata_reg[2:0] == 3'd0, "sample not a sum of level steps")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import tcptg_pkg::*;

    // Selector value that the block has no register for; such writes are dropped.
    localparam logic [1:0] SEL_UNUSED  = 2'd3;
    // Control values used by name in the directed part.
    localparam logic [3:0] CTL_TOGGLE  = 4'd4;
    localparam logic [3:0] CTL_DIV31   = 4'd2;
    localparam logic [3:0] CTL_POLY5   = 4'd15;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         DRAIN_WAIT  = 4;

    typedef struct packed {
        logic       mode;
        logic [1:0] sel;
        logic       ch;
        logic [7:0] wdata;
    } tone_beat_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'd0;   // [0] channel, [8:1] write_data, [15:9] zero
    logic [2:0]  s_tuser  = 3'd0;    // [0] mode, [2:1] reg_select
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;            // [7:0] sample
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    two_channel_poly_tone_generator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Beats waiting to be offered, and the mixed samples that accepted ticks have earned.
    tone_beat_t beat_q[$];
    logic [7:0] sample_expect_q[$];

    int  fault_count = 0;
    int  cycle_count = 0;
    logic in_taken   = 1'b0;
    bit  steady      = 1'b0;   // no sender gaps and no receiver stalls while set
    int  burst_left  = 0;
    int  gap_left    = 0;
    int  ready_left  = 0;
    int  stall_left  = 0;

    // Shadow of the generator: configuration and per-channel state.
    logic [15:0] cfg_divisor;
    logic        cfg_single;
    logic [3:0]  ctl_reg   [2];
    logic [4:0]  freq_reg  [2];
    logic [3:0]  vol_reg   [2];
    logic [6:0]  level     [2];
    logic [5:0]  div_count [2];
    logic [5:0]  div_reload[2];
    logic [4:0]  p5_pos    [2];
    logic [3:0]  p4_pos    [2];
    logic [8:0]  noise9    [2];
    logic [23:0] smp_count;

    function automatic void clear_tone_state();
        cfg_divisor = DIVISOR_RESET;
        cfg_single  = 1'b0;
        for (int ch = 0; ch < 2; ch++) begin
            ctl_reg[ch]    = '0;
            freq_reg[ch]   = '0;
            vol_reg[ch]    = '0;
            level[ch]      = '0;
            div_count[ch]  = '0;
            div_reload[ch] = '0;
            p5_pos[ch]     = '0;
            p4_pos[ch]     = '0;
            noise9[ch]     = 9'd1;
        end
        smp_count = '0;
    endfunction

    function automatic logic [6:0] full_level(input int ch);
        return {vol_reg[ch], 3'b000};
    endfunction

    // A register write re-evaluates the divider; a silent control sets the level to full volume.
    function automatic void reload_divider(input int ch);
        logic [5:0] nv;
        if (ctl_reg[ch] == CTL_SILENT) begin
            nv = 6'd0;
            level[ch] = full_level(ch);
        end else begin
            nv = {1'b0, freq_reg[ch]} + 6'd1;
        end
        if (nv != div_reload[ch]) begin
            div_reload[ch] = nv;
            if (div_count[ch] == 6'd0 || nv == 6'd0)
                div_count[ch] = nv;
        end
    endfunction

    function automatic void advance_channel(input int ch);
        logic [3:0] c;
        logic [4:0] p5;
        logic [3:0] p4;
        logic       gate;
        logic       out_bit;
        c = ctl_reg[ch];
        if (div_count[ch] == 6'd0)
            return;
        if (div_count[ch] > 6'd1) begin
            div_count[ch] = div_count[ch] - 6'd1;
            return;
        end
        div_count[ch] = div_reload[ch];
        p5 = (p5_pos[ch] == P5_LAST) ? 5'd0 : p5_pos[ch] + 5'd1;
        p5_pos[ch] = p5;
        gate = !c[1] || (!c[0] && PATD31[p5]) || (c[0] && PAT5[p5]);
        if (!gate)
            return;
        if (c[2]) begin
            level[ch] = (level[ch] != 7'd0) ? 7'd0 : full_level(ch);
        end else if (c[3]) begin
            if (c == CTL_POLY9) begin
                out_bit    = noise9[ch][0];
                noise9[ch] = {noise9[ch][4] ^ noise9[ch][0], noise9[ch][8:1]};
            end else begin
                out_bit = PAT5[p5];
            end
            level[ch] = out_bit ? full_level(ch) : 7'd0;
        end else begin
            p4 = (p4_pos[ch] == P4_LAST) ? 4'd0 : p4_pos[ch] + 4'd1;
            p4_pos[ch] = p4;
            level[ch] = PAT4[p4] ? full_level(ch) : 7'd0;
        end
    endfunction

    // Applies one accepted beat to the shadow state and queues the sample it earns, if any.
    function automatic void apply_beat(input logic mode, input logic [1:0] sel,
                                       input logic ch, input logic [7:0] wdata);
        int c;
        c = ch;
        if (mode == MODE_WRITE) begin
            case (sel)
                SEL_CONTROL: ctl_reg[c]  = wdata[3:0];
                SEL_FREQ:    freq_reg[c] = wdata[4:0];
                SEL_VOLUME:  vol_reg[c]  = wdata[3:0];
                default:     return;
            endcase
            reload_divider(c);
            return;
        end
        if (!cfg_single)
            advance_channel(0);
        advance_channel(1);
        smp_count = smp_count - SAMPLE_STEP;
        if ($signed(smp_count) < $signed(SAMPLE_STEP)) begin
            smp_count = smp_count + {8'd0, cfg_divisor};
            sample_expect_q.push_back({1'b0, level[0]} + {1'b0, level[1]});
        end
    endfunction

    function automatic void note_fault(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
        if (fault_count < 10)
            $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
        fault_count++;
    endfunction

    // Monitor: both streams are sampled at the rising edge.
    always @(posedge aclk) begin : watch_ports
        logic [7:0] want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                apply_beat(s_tuser[0], s_tuser[2:1], s_tdata[0], s_tdata[8:1]);
            if (m_tvalid && m_tready) begin
                if (sample_expect_q.size() == 0) begin
                    note_fault("sample beat with none due", 8'd0, m_tdata);
                end else begin
                    want = sample_expect_q.pop_front();
                    if (m_tdata !== want)
                        note_fault("sample", want, m_tdata);
                end
            end
        end
    end

    // Sender: bursts of random length separated by random gaps, or no gaps while steady
    // is set. An offered beat stays on the bus, unchanged, until the monitor has seen it taken.
    always @(negedge aclk) begin : drive_input
        tone_beat_t b;
        if (aresetn) begin
            if (in_taken)
                void'(beat_q.pop_front());
            if (s_tvalid && !in_taken) begin
                // still waiting for s_tready
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (beat_q.size() != 0) begin
                b = beat_q[0];
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, b.wdata, b.ch};
                s_tuser  <= {b.sel, b.mode};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= steady ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random-length runs of readiness and stalls; always ready while steady is set.
    always @(negedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else if (ready_left != 0) begin
            ready_left <= ready_left - 1;
            m_tready   <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            ready_left <= $urandom_range(1, 12);
            stall_left <= $urandom_range(0, 9);
            m_tready   <= 1'b1;
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_beat(input logic mode, input logic [1:0] sel, input logic ch,
                             input logic [7:0] wdata);
        beat_q.push_back(tone_beat_t'{mode, sel, ch, wdata});
    endtask

    // Ticks carry random junk in the write fields, which the block must ignore.
    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++)
            push_beat(MODE_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
    endtask

    // Mostly runs of ticks; the rest are full setups of one channel (control, frequency,
    // volume) and lone writes with any selector and any byte.
    task automatic queue_random_items(input int n);
        int         count;
        int         roll;
        int         run;
        logic       ch;
        logic [1:0] sel;
        logic [7:0] fbyte;
        count = 0;
        while (count < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                ch = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < 80)
                    fbyte = {3'($urandom_range(0, 7)), 5'($urandom_range(0, 3))};
                else
                    fbyte = 8'($urandom_range(0, 255));
                push_beat(MODE_WRITE, SEL_CONTROL, ch, 8'($urandom_range(0, 255)));
                push_beat(MODE_WRITE, SEL_FREQ, ch, fbyte);
                push_beat(MODE_WRITE, SEL_VOLUME, ch, 8'($urandom_range(0, 255)));
                count += 3;
            end else if (roll < 20) begin
                sel = 2'($urandom_range(0, 3));
                push_beat(MODE_WRITE, sel, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                if (sel != SEL_UNUSED)
                    count++;
            end else begin
                run = $urandom_range(1, 30);
                push_ticks(run);
                count += run;
            end
        end
    endtask

    // Holds back until the stream has gone quiet and every earned sample has arrived.
    task automatic wait_drained();
        while (beat_q.size() != 0 || s_tvalid || sample_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == CFG_SAMPLE_DIVISOR)
            cfg_divisor = value[15:0];
        else
            cfg_single = value[0];
    endtask

    task automatic run_phase(input logic [15:0] divisor, input logic single,
                             input bit no_idle, input int n);
        wait_drained();
        cfg_write(CFG_SAMPLE_DIVISOR, {16'd0, divisor});
        cfg_write(CFG_SINGLE_CHANNEL, {31'd0, single});
        steady = no_idle;
        queue_random_items(n);
    endtask

    initial begin
        clear_tone_state();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset configuration: masking of wide bytes, both
        // channels, the toggling and nine-bit noise controls, the ignored selector,
        // the silent control forcing the output, and the divide-by-31 gate.
        push_beat(MODE_WRITE, SEL_VOLUME,  1'b0, 8'hFF);
        push_beat(MODE_WRITE, SEL_VOLUME,  1'b1, 8'h0F);
        push_beat(MODE_WRITE, SEL_FREQ,    1'b0, 8'h00);
        push_beat(MODE_WRITE, SEL_FREQ,    1'b1, 8'hFF);
        push_beat(MODE_WRITE, SEL_CONTROL, 1'b0, {4'hF, CTL_TOGGLE});
        push_beat(MODE_WRITE, SEL_CONTROL, 1'b1, {4'hF, CTL_POLY9});
        push_ticks(6);
        push_beat(MODE_WRITE, SEL_UNUSED,  1'b0, 8'hAA);
        push_beat(MODE_WRITE, SEL_CONTROL, 1'b0, {4'h5, CTL_SILENT});
        push_ticks(2);
        push_beat(MODE_WRITE, SEL_CONTROL, 1'b1, {4'h0, CTL_POLY5});
        push_beat(MODE_WRITE, SEL_FREQ,    1'b1, 8'hE0);
        push_beat(MODE_WRITE, SEL_CONTROL, 1'b0, {4'hA, CTL_DIV31});
        push_ticks(5);

        // Random phases over several settings, the range limits among them, plus a
        // divisor below range where the sample counter simply keeps falling.
        run_phase(16'd256,   1'b1, 1'b0, 300);
        run_phase(16'd65535, 1'b0, 1'b0, 300);
        run_phase(16'd0,     1'b0, 1'b0, 100);
        run_phase(16'($urandom_range(256, 1023)), 1'b0, 1'b1, 300);
        run_phase(16'd256,   1'b1, 1'b0, 300);
        run_phase(16'($urandom_range(256, 2000)), 1'b0, 1'b0, 300);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (fault_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
